>>> rtl/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler package
// Shared types and constants for the scheduler and its channel interfaces.
// ----------------------------------------------------------------------------
package mlqs_pkg;

  localparam int ID_W    = 4;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int Q_W     = 8;

  localparam logic [Q_W-1:0] QUANTUM_RST = 8'd2;

  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic LVL_HIGH = 1'b0;
  localparam logic LVL_LOW  = 1'b1;

  typedef struct packed {
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
    logic               started;
    logic [TIME_W-1:0]  first_delay;
  } proc_rec_t;

endpackage

>>> rtl/mlqs_in_if.sv
// ----------------------------------------------------------------------------
// Scheduler request channel
// Carries admit and tick requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlqs_in_if;

  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [mlqs_pkg::ID_W-1:0]       proc_id;
  logic                            level;
  logic [mlqs_pkg::BURST_W-1:0]    burst;

  modport source (output valid, output opcode, output proc_id, output level,
                  output burst, input ready);
  modport sink (input valid, input opcode, input proc_id, input level,
                input burst, output ready);

endinterface

>>> rtl/mlqs_out_if.sv
// ----------------------------------------------------------------------------
// Scheduler result channel
// Carries one result per tick request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlqs_out_if;

  logic                          valid;
  logic                          ready;
  logic                          idle;
  logic [mlqs_pkg::ID_W-1:0]     run_id;
  logic                          run_level;
  logic                          finished;
  logic [mlqs_pkg::TIME_W-1:0]   finish_time;
  logic [mlqs_pkg::TIME_W-1:0]   turnaround;
  logic [mlqs_pkg::TIME_W-1:0]   waiting;
  logic [mlqs_pkg::TIME_W-1:0]   response;

  modport source (output valid, output idle, output run_id, output run_level,
                  output finished, output finish_time, output turnaround,
                  output waiting, output response, input ready);
  modport sink (input valid, input idle, input run_id, input run_level,
                input finished, input finish_time, input turnaround,
                input waiting, input response, output ready);

endinterface

>>> rtl/mlqs_cfg_if.sv
// ----------------------------------------------------------------------------
// Scheduler configuration channel
// Carries writes of the round robin quantum register.
// ----------------------------------------------------------------------------
interface mlqs_cfg_if;

  logic                        valid;
  logic                        ready;
  logic [mlqs_pkg::Q_W-1:0]    rr_quantum;

  modport source (output valid, output rr_quantum, input ready);
  modport sink (input valid, input rr_quantum, output ready);

endinterface

>>> rtl/multilevel_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler
// An admit request is taken in idle and written to the process table in the
// admit state. A tick request steps through decide, queue read when a slice
// starts or level 1 runs, table read and update, and result load.
// An idle tick skips the queue and table steps, and a stalled result holds
// the block. Only one request is in work at a time. Reset clears time,
// queues and slice.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mlqs_cfg_if.sink   cfg_ch,
  mlqs_in_if.sink    in_ch,
  mlqs_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int REC_W = $bits(mlqs_pkg::proc_rec_t);
  localparam int ID_W  = mlqs_pkg::ID_W;
  localparam int TW    = mlqs_pkg::TIME_W;
  localparam int BW    = mlqs_pkg::BURST_W;
  localparam int QW    = mlqs_pkg::Q_W;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PROCS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PROCS - 1);
  localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(MAX_PROCS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADM,
    S_DEC,
    S_QID,
    S_EXE,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [QW-1:0]          quantum_r, quantum_nxt;
  logic [TW-1:0]          time_r, time_nxt;
  logic [MAX_PROCS-1:0]   busy_r, busy_nxt;
  logic [IDX_W-1:0]       hi_head_r, hi_head_nxt;
  logic [CNT_W-1:0]       hi_cnt_r, hi_cnt_nxt;
  logic [IDX_W-1:0]       lo_head_r, lo_head_nxt;
  logic [CNT_W-1:0]       lo_cnt_r, lo_cnt_nxt;
  logic                   slice_act_r, slice_act_nxt;
  logic [ID_W-1:0]        slice_id_r, slice_id_nxt;
  logic [QW-1:0]          slice_left_r, slice_left_nxt;

  logic                   op_r, op_nxt;
  logic [ID_W-1:0]        pid_r, pid_nxt;
  logic                   lvl_r, lvl_nxt;
  logic [BW-1:0]          burst_r, burst_nxt;
  logic                   idle_r, idle_nxt;
  logic                   done_r, done_nxt;
  logic [TW-1:0]          diff_r, diff_nxt;
  logic [TW-1:0]          resp_r, resp_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   o_idle_r, o_idle_nxt;
  logic [ID_W-1:0]        o_id_r, o_id_nxt;
  logic                   o_lvl_r, o_lvl_nxt;
  logic                   o_fin_r, o_fin_nxt;
  logic [TW-1:0]          o_ftime_r, o_ftime_nxt;
  logic [TW-1:0]          o_tat_r, o_tat_nxt;
  logic [TW-1:0]          o_wait_r, o_wait_nxt;
  logic [TW-1:0]          o_resp_r, o_resp_nxt;

  logic                   rec_we;
  logic [IDX_W-1:0]       rec_waddr;
  mlqs_pkg::proc_rec_t    rec_wdata;
  logic [IDX_W-1:0]       rec_raddr;
  mlqs_pkg::proc_rec_t    rec_rdata;

  logic                   hq_we;
  logic [IDX_W-1:0]       hq_waddr;
  logic [ID_W-1:0]        hq_wdata;
  logic [ID_W-1:0]        hq_rdata;

  logic                   lq_we;
  logic [IDX_W-1:0]       lq_waddr;
  logic [ID_W-1:0]        lq_wdata;
  logic [ID_W-1:0]        lq_rdata;

  logic                   adm_ok;
  logic                   load_out;
  logic [ID_W-1:0]        qid;
  logic [SUM_W-1:0]       tail_sum;
  logic [IDX_W-1:0]       tail_idx;
  logic [BW-1:0]          rem_dec;
  logic                   done_w;
  logic [QW-1:0]          left_dec;
  logic [TW-1:0]          diff_w;
  logic [TW-1:0]          tat_w;

  mlqs_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_rec_ram (
    .clk     (clk),
    .we      (rec_we),
    .waddr   (rec_waddr),
    .wdata   (rec_wdata),
    .raddr   (rec_raddr),
    .rd_data (rec_rdata)
  );

  mlqs_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_hq_ram (
    .clk     (clk),
    .we      (hq_we),
    .waddr   (hq_waddr),
    .wdata   (hq_wdata),
    .raddr   (hi_head_r),
    .rd_data (hq_rdata)
  );

  mlqs_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_lq_ram (
    .clk     (clk),
    .we      (lq_we),
    .waddr   (lq_waddr),
    .wdata   (lq_wdata),
    .raddr   (lo_head_r),
    .rd_data (lq_rdata)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.idle        = o_idle_r;
  assign out_ch.run_id      = o_id_r;
  assign out_ch.run_level   = o_lvl_r;
  assign out_ch.finished    = o_fin_r;
  assign out_ch.finish_time = o_ftime_r;
  assign out_ch.turnaround  = o_tat_r;
  assign out_ch.waiting     = o_wait_r;
  assign out_ch.response    = o_resp_r;

  assign qid      = (lvl_r == mlqs_pkg::LVL_LOW) ? lq_rdata : hq_rdata;
  assign rec_raddr = (state_r == S_QID) ? IDX_W'(qid) : IDX_W'(slice_id_r);
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    quantum_nxt    = quantum_r;
    time_nxt       = time_r;
    busy_nxt       = busy_r;
    hi_head_nxt    = hi_head_r;
    hi_cnt_nxt     = hi_cnt_r;
    lo_head_nxt    = lo_head_r;
    lo_cnt_nxt     = lo_cnt_r;
    slice_act_nxt  = slice_act_r;
    slice_id_nxt   = slice_id_r;
    slice_left_nxt = slice_left_r;
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    lvl_nxt        = lvl_r;
    burst_nxt      = burst_r;
    idle_nxt       = idle_r;
    done_nxt       = done_r;
    diff_nxt       = diff_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_idle_nxt     = o_idle_r;
    o_id_nxt       = o_id_r;
    o_lvl_nxt      = o_lvl_r;
    o_fin_nxt      = o_fin_r;
    o_ftime_nxt    = o_ftime_r;
    o_tat_nxt      = o_tat_r;
    o_wait_nxt     = o_wait_r;
    o_resp_nxt     = o_resp_r;
    rec_we         = 1'b0;
    rec_waddr      = IDX_W'(pid_r);
    rec_wdata      = rec_rdata;
    hq_we          = 1'b0;
    hq_waddr       = hi_head_r;
    hq_wdata       = pid_r;
    lq_we          = 1'b0;
    lq_waddr       = lo_head_r;
    lq_wdata       = pid_r;
    adm_ok         = 1'b0;
    tail_sum       = '0;
    tail_idx       = '0;
    rem_dec        = '0;
    done_w         = 1'b0;
    left_dec       = '0;
    diff_w         = '0;
    tat_w          = '0;

    if (cfg_ch.valid) begin
      quantum_nxt = cfg_ch.rr_quantum;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          pid_nxt   = in_ch.proc_id;
          lvl_nxt   = in_ch.level;
          burst_nxt = in_ch.burst;
          state_nxt = (in_ch.opcode == mlqs_pkg::OP_TICK) ? S_DEC : S_ADM;
        end
      end

      S_ADM: begin
        if (lvl_r == mlqs_pkg::LVL_LOW) begin
          tail_sum = SUM_W'(lo_head_r) + SUM_W'(lo_cnt_r);
          adm_ok   = lo_cnt_r < CNT_MAX;
        end else begin
          tail_sum = SUM_W'(hi_head_r) + SUM_W'(hi_cnt_r);
          adm_ok   = hi_cnt_r < CNT_MAX;
        end
        tail_idx = (tail_sum >= SUM_MAX) ? IDX_W'(tail_sum - SUM_MAX) : IDX_W'(tail_sum);
        adm_ok = adm_ok && (32'(pid_r) < 32'(MAX_PROCS)) && (burst_r != '0)
                 && !busy_r[IDX_W'(pid_r)];
        if (adm_ok) begin
          rec_we                = 1'b1;
          rec_waddr             = IDX_W'(pid_r);
          rec_wdata.remaining   = burst_r;
          rec_wdata.burst       = burst_r;
          rec_wdata.arrival     = time_r;
          rec_wdata.started     = 1'b0;
          rec_wdata.first_delay = '0;
          busy_nxt[IDX_W'(pid_r)] = 1'b1;
          if (lvl_r == mlqs_pkg::LVL_LOW) begin
            lq_we      = 1'b1;
            lq_waddr   = tail_idx;
            lo_cnt_nxt = lo_cnt_r + 1'b1;
          end else begin
            hq_we      = 1'b1;
            hq_waddr   = tail_idx;
            hi_cnt_nxt = hi_cnt_r + 1'b1;
          end
        end
        state_nxt = S_IDLE;
      end

      S_DEC: begin
        idle_nxt = 1'b0;
        done_nxt = 1'b0;
        if (!slice_act_r && hi_cnt_r != '0) begin
          hi_head_nxt    = (hi_head_r == IDX_LAST) ? '0 : hi_head_r + 1'b1;
          hi_cnt_nxt     = hi_cnt_r - 1'b1;
          slice_act_nxt  = 1'b1;
          slice_left_nxt = (quantum_r == '0) ? QW'(1) : quantum_r;
          lvl_nxt        = mlqs_pkg::LVL_HIGH;
          state_nxt      = S_QID;
        end else if (slice_act_r) begin
          pid_nxt   = slice_id_r;
          lvl_nxt   = mlqs_pkg::LVL_HIGH;
          state_nxt = S_EXE;
        end else if (lo_cnt_r != '0) begin
          lvl_nxt   = mlqs_pkg::LVL_LOW;
          state_nxt = S_QID;
        end else begin
          idle_nxt  = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_QID: begin
        pid_nxt = qid;
        if (lvl_r == mlqs_pkg::LVL_HIGH) begin
          slice_id_nxt = qid;
        end
        state_nxt = S_EXE;
      end

      S_EXE: begin
        diff_w  = time_r - rec_rdata.arrival;
        rem_dec = (rec_rdata.remaining != '0) ? rec_rdata.remaining - 1'b1 : '0;
        done_w  = (rem_dec == '0);
        rec_we                = 1'b1;
        rec_waddr             = IDX_W'(pid_r);
        rec_wdata.remaining   = rem_dec;
        rec_wdata.started     = 1'b1;
        rec_wdata.first_delay = rec_rdata.started ? rec_rdata.first_delay : diff_w;
        resp_nxt  = rec_wdata.first_delay;
        diff_nxt  = diff_w;
        burst_nxt = rec_rdata.burst;
        done_nxt  = done_w;
        if (lvl_r == mlqs_pkg::LVL_HIGH) begin
          left_dec       = (slice_left_r != '0) ? slice_left_r - 1'b1 : slice_left_r;
          slice_left_nxt = left_dec;
          if (done_w) begin
            slice_act_nxt = 1'b0;
          end else if (left_dec == '0) begin
            slice_act_nxt = 1'b0;
            if (hi_cnt_r < CNT_MAX) begin
              tail_sum   = SUM_W'(hi_head_r) + SUM_W'(hi_cnt_r);
              tail_idx   = (tail_sum >= SUM_MAX) ? IDX_W'(tail_sum - SUM_MAX)
                                                 : IDX_W'(tail_sum);
              hq_we      = 1'b1;
              hq_waddr   = tail_idx;
              hq_wdata   = pid_r;
              hi_cnt_nxt = hi_cnt_r + 1'b1;
            end
          end
        end else if (done_w) begin
          lo_head_nxt = (lo_head_r == IDX_LAST) ? '0 : lo_head_r + 1'b1;
          lo_cnt_nxt  = lo_cnt_r - 1'b1;
        end
        if (done_w) begin
          busy_nxt[IDX_W'(pid_r)] = 1'b0;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (load_out) begin
          tat_w         = diff_r + TW'(1);
          time_nxt      = time_r + TW'(1);
          out_valid_nxt = 1'b1;
          o_idle_nxt    = idle_r;
          o_id_nxt      = idle_r ? '0 : pid_r;
          o_lvl_nxt     = idle_r ? 1'b0 : lvl_r;
          o_fin_nxt     = !idle_r && done_r;
          if (!idle_r && done_r) begin
            o_ftime_nxt = time_r + TW'(1);
            o_tat_nxt   = tat_w;
            o_wait_nxt  = tat_w - TW'(burst_r);
            o_resp_nxt  = resp_r;
          end else begin
            o_ftime_nxt = '0;
            o_tat_nxt   = '0;
            o_wait_nxt  = '0;
            o_resp_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      quantum_r    <= mlqs_pkg::QUANTUM_RST;
      time_r       <= '0;
      busy_r       <= '0;
      hi_head_r    <= '0;
      hi_cnt_r     <= '0;
      lo_head_r    <= '0;
      lo_cnt_r     <= '0;
      slice_act_r  <= 1'b0;
      slice_id_r   <= '0;
      slice_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      quantum_r    <= quantum_nxt;
      time_r       <= time_nxt;
      busy_r       <= busy_nxt;
      hi_head_r    <= hi_head_nxt;
      hi_cnt_r     <= hi_cnt_nxt;
      lo_head_r    <= lo_head_nxt;
      lo_cnt_r     <= lo_cnt_nxt;
      slice_act_r  <= slice_act_nxt;
      slice_id_r   <= slice_id_nxt;
      slice_left_r <= slice_left_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      pid_r        <= pid_nxt;
      lvl_r        <= lvl_nxt;
      burst_r      <= burst_nxt;
      idle_r       <= idle_nxt;
      done_r       <= done_nxt;
      diff_r       <= diff_nxt;
      resp_r       <= resp_nxt;
      o_idle_r     <= o_idle_nxt;
      o_id_r       <= o_id_nxt;
      o_lvl_r      <= o_lvl_nxt;
      o_fin_r      <= o_fin_nxt;
      o_ftime_r    <= o_ftime_nxt;
      o_tat_r      <= o_tat_nxt;
      o_wait_r     <= o_wait_nxt;
      o_resp_r     <= o_resp_nxt;
    end
  end

`ifndef SYNTHESIS
  // Neither queue count exceeds its capacity of MAX_PROCS entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (hi_cnt_r <= CNT_MAX) && (lo_cnt_r <= CNT_MAX))
    else $error("queue count beyond capacity");

  // Between requests every busy process is queued or owns the running slice.
  a_busy_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ($countones(busy_r) == int'(hi_cnt_r) + int'(lo_cnt_r) + int'(slice_act_r)))
    else $error("busy processes and queued entries disagree");

  // The time counter moves by one exactly when a tick result is loaded.
  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (time_r == $past(time_r) + TW'(1)) && out_valid_r)
    else $error("time counter did not advance with the result");

  // An admit request never produces a result.
  a_admit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADM) |=> (state_r == S_IDLE) && (op_r == mlqs_pkg::OP_ADMIT))
    else $error("admit request did not return to idle");
`endif

endmodule

>>> rtl/mlqs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mlqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule
